// File: hdl/arp_pkg.sv
// ----------------------------------------------------------------------------
// arp_pkg
// Shared types, codes and constants for the up-pattern note arpeggiator.
// ----------------------------------------------------------------------------
`default_nettype none

package arp_pkg;

  // Default sizes
  localparam int MAX_HELD_DEF    = 16;
  localparam int MAX_OCTAVES_DEF = 4;
  localparam int PHASE_BITS_DEF  = 32;

  // Field widths
  localparam int NOTE_W = 7;
  localparam int MSG_W  = 24;
  localparam int CFG_W  = 32;
  localparam int OCT_W  = 3;

  // Musical constants
  localparam int NOTE_MAX  = 127;
  localparam int SEMITONES = 12;

  // Register reset values and legal ranges
  localparam logic [CFG_W-1:0] STEP_RESET = 32'd715828;
  localparam logic [CFG_W-1:0] STEP_MIN   = 32'd1;
  localparam logic [CFG_W-1:0] STEP_MAX   = 32'd2147483648;
  localparam logic [CFG_W-1:0] GATE_RESET = 32'd2147483648;
  localparam logic [CFG_W-1:0] GATE_MIN   = 32'd214748365;
  localparam logic [CFG_W-1:0] GATE_MAX   = 32'd4080218931;
  localparam logic [OCT_W-1:0] OCT_RESET  = 3'd1;
  localparam logic [OCT_W-1:0] OCT_MIN    = 3'd1;

  // Register indexes
  localparam logic [1:0] CFG_PHASE_STEP   = 2'd0;
  localparam logic [1:0] CFG_GATE_LEVEL   = 2'd1;
  localparam logic [1:0] CFG_OCTAVE_COUNT = 2'd2;

  // Input operation codes
  localparam logic [1:0] OP_NOTE_ON  = 2'd0;
  localparam logic [1:0] OP_NOTE_OFF = 2'd1;
  localparam logic [1:0] OP_MESSAGE  = 2'd2;
  localparam logic [1:0] OP_TICK     = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_NOTE_OFF = 2'd0;
  localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
  localparam logic [1:0] KIND_MESSAGE  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMP,
    S_EDIT,
    S_PASS,
    S_TICK,
    S_CHECK,
    S_MOD,
    S_DIV_GO,
    S_DIV,
    S_NOTE,
    S_OFF,
    S_ON
  } arp_state_t;

  // Command bundle broadcast to every cell of the note chain
  typedef struct packed {
    logic              cmp;  // capture compare flags against key
    logic              ins;  // insert key, shifting larger notes up
    logic              del;  // remove key, shifting larger notes down
    logic [NOTE_W-1:0] key;
  } arp_cell_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/arp_cell.sv
// ----------------------------------------------------------------------------
// arp_cell
// One slot of the sorted held-note chain: stores a note, compares it with
// the key and trades values with its neighbors on insert and delete.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_cell (
  input  logic                                clk,
  input  arp_pkg::arp_cell_ctrl_t             ctrl,
  input  logic                                active,
  input  logic [arp_pkg::NOTE_W-1:0]          prev_note,
  input  logic                                prev_gt,
  input  logic [arp_pkg::NOTE_W-1:0]          next_note,
  output logic [arp_pkg::NOTE_W-1:0]          note,
  output logic                                gt,
  output logic                                eq
);
  import arp_pkg::*;

  logic [NOTE_W-1:0] held;
  logic              gt_c;
  logic              eq_c;

  // Empty slots count as "above" the key so an insert lands at the end.
  assign gt_c = !active || (held > ctrl.key);
  assign eq_c = active && (held == ctrl.key);

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      gt <= gt_c;
      eq <= eq_c;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins && gt) begin
      held <= prev_gt ? prev_note : ctrl.key;
    end else if (ctrl.del && (gt || eq)) begin
      held <= next_note;
    end
  end

  assign note = held;

endmodule

`default_nettype wire

// File: hdl/arp_div.sv
// ----------------------------------------------------------------------------
// arp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_div #(
  parameter int W = 7
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);
  import arp_pkg::*;

  localparam int CNT_W = $clog2(W + 1);

  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     dvs;
  logic [W:0]       shifted;
  logic [W:0]       diff;
  logic             qbit;
  logic [W-1:0]     rem_next;

  always_comb begin
    shifted = {remainder, quotient[W-1]};
    diff    = shifted - {1'b0, dvs};
    qbit    = !diff[W];
    rem_next = qbit ? diff[W-1:0] : shifted[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[W-2:0], qbit};
      remainder <= rem_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/note_arpeggiator_up.sv
// ----------------------------------------------------------------------------
// note_arpeggiator_up
// Up-pattern arpeggiator: sorted held-note chain, phase accumulator and a
// shared divider that picks the pattern slot and octave on each wrap.
// ----------------------------------------------------------------------------
//
//  channel  signals                                  dir  notes
//  -------  ---------------------------------------  ---  --------------------
//  item     item_valid item_stall op note message     in   one event per transfer
//  result   result_valid result_stall out_kind        out  up to 2 per item,
//           out_note out_message last                      last marks the final
//  config   cfg_write cfg_index cfg_data              in   write only, idle only
//
//  Note on/off: a compare state, then an edit state. Pass-through message:
//  waits for a free result register. Tick without wrap: at most a note-off.
//  Tick with wrap: two passes of the shared bit-serial divider pick slot
//  and octave, then a note-off (if one is due) and the note-on go out.
//  Reset clears control, phase, step, count and registers at once; the
//  held-note chain holds garbage until written and needs no clearing pass.
//  A stalled result holds the output register; the block waits in its emit
//  state and takes no new item until its last result is loaded there.
//
`default_nettype none

module note_arpeggiator_up #(
  parameter int MAX_HELD    = arp_pkg::MAX_HELD_DEF,
  parameter int MAX_OCTAVES = arp_pkg::MAX_OCTAVES_DEF,
  parameter int PHASE_BITS  = arp_pkg::PHASE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // item channel
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic [1:0]                   op,
  input  logic [arp_pkg::NOTE_W-1:0]   note,
  input  logic [arp_pkg::MSG_W-1:0]    message,
  // result channel
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [1:0]                   out_kind,
  output logic [arp_pkg::NOTE_W-1:0]   out_note,
  output logic [arp_pkg::MSG_W-1:0]    out_message,
  output logic                         last,
  // configuration
  input  logic                         cfg_write,
  input  logic [1:0]                   cfg_index,
  input  logic [arp_pkg::CFG_W-1:0]    cfg_data
);
  import arp_pkg::*;

  // Count of held notes, pattern step and slot widths
  localparam int CW  = $clog2(MAX_HELD + 1);
  localparam int SW  = $clog2(MAX_HELD * MAX_OCTAVES + 1);
  localparam int SLW = $clog2(MAX_HELD);
  localparam int PB  = PHASE_BITS;
  // Q0.32 register alignment onto the accumulator
  localparam int UP  = (PB > 32) ? PB - 32 : 0;
  localparam int DN  = (PB < 32) ? 32 - PB : 0;
  localparam int XW  = 32 + UP;

  function automatic logic [PB-1:0] align_q32(input logic [31:0] x);
    logic [XW-1:0] t;
    t = (XW'(x) << UP) >> DN;
    return t[PB-1:0];
  endfunction

  // -------------------------------------------------------------------------
  // Configuration, saturated on write
  // -------------------------------------------------------------------------
  logic [CFG_W-1:0] phase_step;
  logic [CFG_W-1:0] gate_level;
  logic [OCT_W-1:0] octave_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step   <= STEP_RESET;
      gate_level   <= GATE_RESET;
      octave_count <= OCT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PHASE_STEP: begin
          if (cfg_data < STEP_MIN) phase_step <= STEP_MIN;
          else if (cfg_data > STEP_MAX) phase_step <= STEP_MAX;
          else phase_step <= cfg_data;
        end
        CFG_GATE_LEVEL: begin
          if (cfg_data < GATE_MIN) gate_level <= GATE_MIN;
          else if (cfg_data > GATE_MAX) gate_level <= GATE_MAX;
          else gate_level <= cfg_data;
        end
        CFG_OCTAVE_COUNT: begin
          if (cfg_data[OCT_W-1:0] < OCT_MIN) octave_count <= OCT_MIN;
          else if ({1'b0, cfg_data[OCT_W-1:0]} > 4'(MAX_OCTAVES))
            octave_count <= OCT_W'(MAX_OCTAVES);
          else octave_count <= cfg_data[OCT_W-1:0];
        end
        default: ;  // unused index: ignored
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Control and datapath state
  // -------------------------------------------------------------------------
  arp_state_t        state, state_next;
  logic [1:0]        op_r;
  logic [NOTE_W-1:0] note_r;
  logic [MSG_W-1:0]  msg_r;

  logic [CW-1:0]     count;
  logic [SW-1:0]     step;
  logic [PB:0]       phase;        // one extra bit catches the wrap
  logic              sound_valid;
  logic [NOTE_W-1:0] sound_note;
  logic [SW-1:0]     span_r;
  logic [SW-1:0]     idx_r;
  logic              off_need;
  logic              on_need;
  logic [NOTE_W-1:0] play_note;

  logic              out_free;
  logic              found;
  logic              full;
  logic              gate_hit;
  logic              wrap;

  // Note chain
  arp_cell_ctrl_t    cell_ctrl;
  logic [NOTE_W-1:0] held [MAX_HELD];
  logic [MAX_HELD-1:0] gt_v;
  logic [MAX_HELD-1:0] eq_v;
  logic [MAX_HELD-1:0] active;
  logic [NOTE_W-1:0] rd_note;

  // Divider
  logic              div_start;
  logic [SW-1:0]     div_dividend;
  logic [SW-1:0]     div_divisor;
  logic              div_busy;
  logic              div_done;
  logic [SW-1:0]     div_quo;
  logic [SW-1:0]     div_rem;

  // Result load
  logic              out_load;
  logic [1:0]        ld_kind;
  logic [NOTE_W-1:0] ld_note;
  logic [MSG_W-1:0]  ld_msg;
  logic              ld_last;

  logic [8:0]        note_sum;

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state != S_IDLE);
  assign found      = |eq_v;
  assign full       = (count == CW'(MAX_HELD));
  assign gate_hit   = phase >= {1'b0, align_q32(gate_level)};
  assign wrap       = phase[PB];

  // -------------------------------------------------------------------------
  // Sorted chain of held notes
  // -------------------------------------------------------------------------
  for (genvar i = 0; i < MAX_HELD; i++) begin : g_cell
    logic [NOTE_W-1:0] prev_n;
    logic              prev_g;
    logic [NOTE_W-1:0] next_n;

    assign active[i] = CW'(i) < count;

    if (i == 0) begin : g_first
      assign prev_n = '0;
      assign prev_g = 1'b0;
    end else begin : g_mid
      assign prev_n = held[i-1];
      assign prev_g = gt_v[i-1];
    end

    if (i == MAX_HELD - 1) begin : g_last
      assign next_n = held[i];
    end else begin : g_inner
      assign next_n = held[i+1];
    end

    arp_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .active    (active[i]),
      .prev_note (prev_n),
      .prev_gt   (prev_g),
      .next_note (next_n),
      .note      (held[i]),
      .gt        (gt_v[i]),
      .eq        (eq_v[i])
    );
  end

  // Slot read: the divider remainder picks one cell
  always_comb begin
    rd_note = '0;
    for (int i = 0; i < MAX_HELD; i++) begin
      if (div_rem[SLW-1:0] == SLW'(i)) rd_note = rd_note | held[i];
    end
  end

  assign note_sum = 9'(rd_note) + 9'(div_quo) * 9'(SEMITONES);

  arp_div #(.W(SW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next     = state;
    cell_ctrl.cmp  = 1'b0;
    cell_ctrl.ins  = 1'b0;
    cell_ctrl.del  = 1'b0;
    cell_ctrl.key  = note_r;
    div_start      = 1'b0;
    div_dividend   = step;
    div_divisor    = span_r;
    out_load       = 1'b0;
    ld_kind        = KIND_NOTE_OFF;
    ld_note        = '0;
    ld_msg         = '0;
    ld_last        = 1'b1;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          case (op)
            OP_MESSAGE: state_next = S_PASS;
            OP_TICK:    state_next = S_TICK;
            default:    state_next = S_CMP;
          endcase
        end
      end
      S_CMP: begin
        cell_ctrl.cmp = 1'b1;
        state_next    = S_EDIT;
      end
      S_EDIT: begin
        if (op_r == OP_NOTE_ON && !found && !full) cell_ctrl.ins = 1'b1;
        if (op_r == OP_NOTE_OFF && found) cell_ctrl.del = 1'b1;
        state_next = S_IDLE;
      end
      S_PASS: begin
        if (out_free) begin
          out_load   = 1'b1;
          ld_kind    = KIND_MESSAGE;
          ld_msg     = msg_r;
          state_next = S_IDLE;
        end
      end
      S_TICK: begin
        if (count == '0) state_next = sound_valid ? S_OFF : S_IDLE;
        else state_next = S_CHECK;
      end
      S_CHECK: begin
        if (wrap) begin
          div_start  = 1'b1;
          state_next = S_MOD;
        end else if (gate_hit && sound_valid) begin
          state_next = S_OFF;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MOD: begin
        if (div_done) state_next = S_DIV_GO;
      end
      S_DIV_GO: begin
        div_start    = 1'b1;
        div_dividend = div_rem;
        div_divisor  = SW'(count);
        state_next   = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_next = S_NOTE;
      end
      S_NOTE: begin
        state_next = off_need ? S_OFF : S_ON;
      end
      S_OFF: begin
        if (out_free) begin
          out_load   = 1'b1;
          ld_kind    = KIND_NOTE_OFF;
          ld_note    = sound_note;
          ld_last    = !on_need;
          state_next = on_need ? S_ON : S_IDLE;
        end
      end
      S_ON: begin
        if (out_free) begin
          out_load   = 1'b1;
          ld_kind    = KIND_NOTE_ON;
          ld_note    = play_note;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Item capture and scratch registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) begin
      op_r   <= op;
      note_r <= note;
      msg_r  <= message;
    end
    if (state == S_TICK) span_r <= SW'(SW'(count) * SW'(octave_count));
    if (state == S_DIV_GO) idx_r <= div_rem;
    if (state == S_NOTE) begin
      play_note <= (note_sum > 9'(NOTE_MAX)) ? NOTE_W'(NOTE_MAX) : note_sum[NOTE_W-1:0];
    end
  end

  // Arpeggio state
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      step        <= '0;
      phase       <= '0;
      sound_valid <= 1'b0;
      sound_note  <= '0;
      off_need    <= 1'b0;
      on_need     <= 1'b0;
    end else begin
      if (cell_ctrl.ins) count <= count + 1'b1;
      if (cell_ctrl.del) count <= count - 1'b1;
      case (state)
        S_TICK: begin
          if (count == '0) begin
            phase    <= '0;
            step     <= '0;
            off_need <= sound_valid;
            on_need  <= 1'b0;
          end else begin
            phase <= phase + {1'b0, align_q32(phase_step)};
          end
        end
        S_CHECK: begin
          off_need <= sound_valid && (gate_hit || wrap);
          on_need  <= wrap;
          if (wrap) phase[PB] <= 1'b0;  // subtract one
        end
        S_OFF: begin
          if (out_free) sound_valid <= 1'b0;
        end
        S_ON: begin
          if (out_free) begin
            sound_valid <= 1'b1;
            sound_note  <= play_note;
            step        <= (idx_r + 1'b1 == span_r) ? '0 : idx_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind    <= ld_kind;
      out_note    <= ld_note;
      out_message <= ld_msg;
      last        <= ld_last;
    end
  end

  // -------------------------------------------------------------------------
  // Checks
  // -------------------------------------------------------------------------
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_HELD))
    else $error("held count beyond capacity");

  a_phase_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !phase[PB])
    else $error("phase left above one");

  a_on_sounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_ON && out_free) |=> (sound_valid && sound_note == $past(play_note)))
    else $error("note-on did not update sounding note");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ON && out_free) |=> (step < span_r))
    else $error("pattern step out of span");

  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

`default_nettype wire

// File: dv/note_arpeggiator_up_tb.sv
// ----------------------------------------------------------------------------
// note_arpeggiator_up_tb
// Self-checking bench for the up-pattern arpeggiator. A short directed run
// covers message extremes, duplicate and unheld notes, empty ticks, octave
// clamping and gate/wrap ordering. Random phases with fresh register
// settings follow. A cycle-free model of the block predicts every result,
// and the monitor checks each transfer against it. Both channels idle in
// random bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module note_arpeggiator_up_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import arp_pkg::*;

  // Index past the end of the register list; the block must ignore it.
  localparam logic [1:0] CFG_SPARE = 2'd3;

  // Worst tick-with-wrap is two divider passes; this is well past it.
  localparam int SETTLE_CYCLES   = 200;
  localparam int TIMEOUT_NS      = 5_000_000;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 62;
  localparam int LOG_LIMIT       = 40;

  // Random traffic flavors: build chords, steady play, or let the chord thin out.
  typedef enum int {MIX_FILL, MIX_PLAY, MIX_THIN} mix_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [NOTE_W-1:0] note;
    logic [MSG_W-1:0]  message;
  } midi_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [NOTE_W-1:0] note;
    logic [MSG_W-1:0]  message;
    logic              last;
  } midi_event_t;

  // Block ports. Every input has a known value from time zero.
  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  logic [1:0]        op           = OP_MESSAGE;
  logic [NOTE_W-1:0] note         = '0;
  logic [MSG_W-1:0]  message      = '0;
  logic              result_stall = 1'b0;
  logic              cfg_write    = 1'b0;
  logic [1:0]        cfg_index    = CFG_PHASE_STEP;
  logic [CFG_W-1:0]  cfg_data     = '0;
  wire               item_stall;
  wire               result_valid;
  wire  [1:0]        out_kind;
  wire  [NOTE_W-1:0] out_note;
  wire  [MSG_W-1:0]  out_message;
  wire               last;

  note_arpeggiator_up dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .op           (op),
    .note         (note),
    .message      (message),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_kind     (out_kind),
    .out_note     (out_note),
    .out_message  (out_message),
    .last         (last),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Arpeggiator model: its own copy of registers and held-note state.
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0]  step_reg = STEP_RESET;
  logic [CFG_W-1:0]  gate_reg = GATE_RESET;
  logic [OCT_W-1:0]  oct_reg  = OCT_RESET;

  logic [NOTE_W-1:0] chord [MAX_HELD_DEF];  // held notes, ascending
  int unsigned       chord_n       = 0;
  int unsigned       pattern_pos   = 0;
  logic [32:0]       phase_acc     = '0;    // Q1.32, bit 32 is the wrap
  logic              sounding      = 1'b0;
  logic [NOTE_W-1:0] sounding_note = '0;

  midi_item_t  midi_in_q[$];   // items waiting for the driver
  midi_event_t midi_out_q[$];  // predicted results, oldest first
  int unsigned items_queued  = 0;
  int unsigned items_taken   = 0;
  int unsigned mismatch_count = 0;

  // Pacing knobs set per phase; 0 odds means no idle bursts at all.
  int unsigned burst_odds = 4;
  logic        calm       = 1'b0;

  // Apply one accepted item to the model and queue what the block must emit.
  function automatic void arp_respond(midi_item_t it);
    midi_event_t      burst[$];
    logic [CFG_W-1:0] inc;
    logic [CFG_W-1:0] gate;
    int unsigned      octs;
    int unsigned      span;
    int unsigned      idx;
    int unsigned      pos;
    int unsigned      k;
    int unsigned      pitch;
    logic             already;

    already = 1'b0;
    case (it.op)
      OP_NOTE_ON: begin
        for (k = 0; k < chord_n; k++)
          if (chord[k] == it.note) already = 1'b1;
        // duplicates and a full chord are dropped silently
        if (!already && chord_n < MAX_HELD_DEF) begin
          pos = chord_n;
          while (pos > 0 && chord[pos-1] > it.note) begin
            chord[pos] = chord[pos-1];
            pos--;
          end
          chord[pos] = it.note;
          chord_n++;
        end
      end
      OP_NOTE_OFF: begin
        pos = chord_n;
        for (k = 0; k < chord_n; k++)
          if (chord[k] == it.note && pos == chord_n) pos = k;
        if (pos < chord_n) begin
          for (k = pos; k + 1 < chord_n; k++) chord[k] = chord[k+1];
          chord_n--;
        end
      end
      OP_MESSAGE: begin
        burst.push_back({KIND_MESSAGE, {NOTE_W{1'b0}}, it.message, 1'b0});
      end
      default: begin
        if (chord_n == 0) begin
          // empty chord: end whatever sounds, restart the pattern
          if (sounding)
            burst.push_back({KIND_NOTE_OFF, sounding_note, {MSG_W{1'b0}}, 1'b0});
          sounding    = 1'b0;
          phase_acc   = '0;
          pattern_pos = 0;
        end else begin
          inc  = (step_reg < STEP_MIN) ? STEP_MIN :
                 (step_reg > STEP_MAX) ? STEP_MAX : step_reg;
          gate = (gate_reg < GATE_MIN) ? GATE_MIN :
                 (gate_reg > GATE_MAX) ? GATE_MAX : gate_reg;
          octs = (oct_reg < OCT_MIN) ? 1 :
                 (oct_reg > MAX_OCTAVES_DEF) ? MAX_OCTAVES_DEF : int'(oct_reg);
          phase_acc = phase_acc + {1'b0, inc};
          // gate note-off goes out ahead of any note-on from the same tick
          if (sounding && phase_acc >= {1'b0, gate}) begin
            burst.push_back({KIND_NOTE_OFF, sounding_note, {MSG_W{1'b0}}, 1'b0});
            sounding = 1'b0;
          end
          if (phase_acc[32]) begin
            phase_acc[32] = 1'b0;
            span  = chord_n * octs;
            idx   = pattern_pos % span;
            pitch = chord[idx % chord_n] + SEMITONES * (idx / chord_n);
            if (pitch > NOTE_MAX) pitch = NOTE_MAX;
            if (sounding)
              burst.push_back({KIND_NOTE_OFF, sounding_note, {MSG_W{1'b0}}, 1'b0});
            burst.push_back({KIND_NOTE_ON, pitch[NOTE_W-1:0], {MSG_W{1'b0}}, 1'b0});
            sounding      = 1'b1;
            sounding_note = pitch[NOTE_W-1:0];
            pattern_pos   = (pattern_pos + 1) % span;
          end
        end
      end
    endcase
    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[e]) midi_out_q.push_back(burst[e]);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= LOG_LIMIT) $display("%0t ns mismatch: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Driver: one item per transfer, random idle bursts between items.
  // The payload holds still while stalled.
  // --------------------------------------------------------------------------
  midi_item_t  on_wire;
  int unsigned send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (item_valid && !item_stall) begin
        arp_respond(on_wire);
        items_taken++;
      end
      if (item_valid && item_stall) begin
        // stalled: hold everything
      end else if (send_gap > 0) begin
        send_gap--;
        item_valid <= 1'b0;
      end else if (!calm && burst_odds != 0 && $urandom_range(1, burst_odds) == 1) begin
        send_gap = $urandom_range(0, 13);
        item_valid <= 1'b0;
      end else if (midi_in_q.size() > 0) begin
        on_wire = midi_in_q.pop_front();
        item_valid <= 1'b1;
        op         <= on_wire.op;
        note       <= on_wire.note;
        message    <= on_wire.message;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each result transfer and stall the result side in bursts.
  // --------------------------------------------------------------------------
  int unsigned stall_left = 0;
  midi_event_t want;

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (midi_out_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d note %0d msg %06h",
                                    out_kind, out_note, out_message));
        end else begin
          want = midi_out_q.pop_front();
          if (out_kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", out_kind, want.kind));
          if (out_note !== want.note)
            report_mismatch($sformatf("note %0d, expected %0d", out_note, want.note));
          if (out_message !== want.message)
            report_mismatch($sformatf("message %06h, expected %06h",
                                      out_message, want.message));
          if (last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
        end
      end
      if (calm) begin
        result_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else if (burst_odds != 0 && $urandom_range(1, burst_odds + 3) == 1) begin
        stall_left = $urandom_range(0, 13);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic send(input logic [1:0] o, input logic [NOTE_W-1:0] n,
                      input logic [MSG_W-1:0] m);
    midi_in_q.push_back({o, n, m});
    items_queued++;
  endtask

  // Hold off until every item has transferred and every result is back,
  // then give the block time to finish items that emit nothing.
  task automatic settle();
    while (items_taken != items_queued || midi_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Back-to-back register writes; write enable drops once at the end.
  task automatic configure(input logic [CFG_W-1:0] stp, input logic [CFG_W-1:0] gte,
                           input logic [OCT_W-1:0] oct, input logic spare);
    logic [CFG_W-1:0] junk;

    junk = $urandom();
    cfg_write <= 1'b1;
    cfg_index <= CFG_PHASE_STEP;
    cfg_data  <= stp;
    @(posedge clk);
    step_reg = stp;
    cfg_index <= CFG_GATE_LEVEL;
    cfg_data  <= gte;
    @(posedge clk);
    gate_reg = gte;
    // upper bits are noise; only the low octave bits count
    cfg_index <= CFG_OCTAVE_COUNT;
    cfg_data  <= {junk[CFG_W-1:OCT_W], oct};
    @(posedge clk);
    oct_reg = oct;
    if (spare) begin
      cfg_index <= CFG_SPARE;
      cfg_data  <= ~junk;
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic queue_random(input mix_t mix);
    int unsigned roll;
    logic [1:0]  o;
    logic [NOTE_W-1:0] n;

    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: o = (roll < 45) ? OP_NOTE_ON : (roll < 55) ? OP_NOTE_OFF :
                    (roll < 60) ? OP_MESSAGE : OP_TICK;
      MIX_PLAY: o = (roll < 20) ? OP_NOTE_ON : (roll < 40) ? OP_NOTE_OFF :
                    (roll < 50) ? OP_MESSAGE : OP_TICK;
      default:  o = (roll < 5)  ? OP_NOTE_ON : (roll < 45) ? OP_NOTE_OFF :
                    (roll < 55) ? OP_MESSAGE : OP_TICK;
    endcase
    // a narrow pool makes duplicates, real note-offs and a full chord common
    if (o == OP_NOTE_ON || o == OP_NOTE_OFF)
      n = NOTE_W'((mix != MIX_THIN && $urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                                 : $urandom_range(40, 59));
    else
      n = NOTE_W'($urandom_range(0, 127));
    send(o, n, MSG_W'($urandom_range(0, 24'hFF_FFFF)));
  endtask

  initial begin : stimulus
    int unsigned ph;
    int unsigned k;
    logic [CFG_W-1:0] stp;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: pass-through extremes, empty tick, chord edits.
    send(OP_MESSAGE, 7'd0, 24'h00_0000);
    send(OP_MESSAGE, 7'd127, 24'hFF_FFFF);
    send(OP_TICK, 7'd0, 24'h00_0000);       // nothing held, nothing sounding
    send(OP_NOTE_ON, 7'd127, 24'h00_0000);
    send(OP_NOTE_ON, 7'd0, 24'hFF_FFFF);
    send(OP_NOTE_ON, 7'd127, 24'h00_0000);  // duplicate, dropped
    send(OP_NOTE_OFF, 7'd64, 24'h00_0000);  // not held, dropped
    send(OP_TICK, 7'd127, 24'hFF_FFFF);
    settle();

    // Step above range, gate below range, octaves above range: fast wraps,
    // gate ends each note, high octaves clamp at the top note.
    configure(32'hFFFF_FFFF, 32'h0000_0000, 3'd7, 1'b0);
    for (k = 0; k < 8; k++) send(OP_TICK, 7'd0, 24'h00_0000);
    send(OP_NOTE_OFF, 7'd0, 24'h00_0000);
    send(OP_NOTE_OFF, 7'd127, 24'h00_0000);
    send(OP_TICK, 7'd0, 24'h00_0000);       // chord empty, note still sounding
    send(OP_TICK, 7'd0, 24'h00_0000);
    settle();

    // Spare index write, gate above range, zero octaves: gate and wrap
    // fall on the same tick.
    configure(STEP_MAX, 32'hFFFF_FFFF, 3'd0, 1'b1);
    send(OP_NOTE_ON, 7'd60, 24'h00_0000);
    for (k = 0; k < 4; k++) send(OP_TICK, 7'd0, 24'h00_0000);
    settle();

    // Random phases, each with fresh settings; the last one runs flat out.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0:       stp = STEP_MAX + $urandom_range(0, 32'h7FFF_FFFF);
        1:       stp = STEP_MAX;
        default: stp = $urandom_range(32'h0800_0000, 32'h8000_0000);
      endcase
      configure(stp, $urandom(), OCT_W'($urandom_range(0, 7)), ph % 4 == 1);
      case ($urandom_range(0, 2))
        0:       burst_odds = 0;
        1:       burst_odds = 3;
        default: burst_odds = 8;
      endcase
      calm = (ph == RANDOM_PHASES - 1);
      for (k = 0; k < ITEMS_PER_PHASE; k++) queue_random(mix_t'(ph % 3));
      settle();
    end

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Run guard, several times the slowest legal run.
  initial begin
    #(TIMEOUT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
hdl/arp_pkg.sv
hdl/arp_cell.sv
hdl/arp_div.sv
hdl/note_arpeggiator_up.sv
dv/note_arpeggiator_up_tb.sv
